### hdl/lz4bd_pkg.sv
// Package for the LZ4 block decoder: sizes, phase and result codes, and item types.
// It has no dependencies. The top level and the port checker both use it.
`default_nettype none

package lz4bd_pkg;

    localparam int WINDOW_BYTES = 65536;
    localparam int HIST_AW      = $clog2(WINDOW_BYTES);
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
    localparam int STALL_LEVEL  = FIFO_DEPTH - 4;

    localparam logic [3:0]  NIBBLE_EXT  = 4'hF;
    localparam logic [7:0]  EXT_MORE    = 8'd255;
    localparam logic [31:0] MIN_MATCH   = 32'd4;

    typedef enum logic [7:0] {
        PH_TOKEN    = 8'b0000_0001,
        PH_LITEXT   = 8'b0000_0010,
        PH_LITERALS = 8'b0000_0100,
        PH_OFF_LO   = 8'b0000_1000,
        PH_OFF_HI   = 8'b0001_0000,
        PH_MATEXT   = 8'b0010_0000,
        PH_MATCH    = 8'b0100_0000,
        PH_DRAIN    = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        OUT_BYTE   = 2'd0,
        OUT_FINISH = 2'd1,
        OUT_ERROR  = 2'd2
    } t_out_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_ZERO_OFF  = 3'd1,
        ERR_FAR_OFF   = 3'd2,
        ERR_CAPACITY  = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_ORDER     = 3'd5
    } t_err_code;

    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  data;
        t_err_code   code;
        logic [31:0] left;
        logic [31:0] prod;
        logic        fin;
    } t_result;

    typedef struct packed {
        logic               byte_v;
        logic               from_mem;
        logic [7:0]         lit_byte;
        logic [31:0]        match_left;
        logic [31:0]        produced;
        logic               end_v;
        t_out_kind          end_kind;
        t_err_code          end_code;
        logic               wr;
        logic [HIST_AW-1:0] waddr;
    } t_stage;

endpackage

`default_nettype wire

### hdl/lz4_block_decompressor.sv
// LZ4 block decoder: parser state in registers, 64 KiB history in one synchronous RAM.
// Depends on lz4bd_pkg. An accepted item goes to stage r_s1, then into the result queue.
// One item per cycle if not stalled; each item yields up to two results in an 8-entry queue.
// The history RAM is read once and written once per cycle, with a bypass for a copy
// of the byte written in the cycle before. Reset is synchronous, clears the parser and
// the queue and sets the capacity register to all ones; the history RAM is not cleared.
`default_nettype none

module lz4_block_decompressor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_error_code,
    output logic [31:0]      o_match_left,
    output logic [31:0]      o_produced,
    output logic             o_block_end
);

    lz4bd_pkg::t_phase                r_phase, n_phase;
    logic [31:0]                      r_lit, n_lit;
    logic [3:0]                       r_nib, n_nib;
    logic [lz4bd_pkg::HIST_AW-1:0]    r_off, n_off;
    logic [31:0]                      r_rem, n_rem;
    logic [31:0]                      r_prod, n_prod;
    logic                             r_ended, n_ended;
    logic [31:0]                      r_cap, n_cap;
    logic [31:0]                      r_room, n_room;
    logic                             r_room_ok, n_room_ok;

    lz4bd_pkg::t_stage                r_s1, n_s1;
    logic                             r_s1_valid;
    logic                             r_fwd;
    logic [7:0]                       r_fwd_data;
    logic [7:0]                       r_mem_q;
    logic [7:0]                       r_hist [lz4bd_pkg::WINDOW_BYTES];

    lz4bd_pkg::t_result               r_fifo [lz4bd_pkg::FIFO_DEPTH];
    logic [lz4bd_pkg::FIFO_AW-1:0]    r_wp, r_rp;
    logic [lz4bd_pkg::FIFO_CW-1:0]    r_count;

    logic                             acc;
    logic [lz4bd_pkg::HIST_AW-1:0]    rd_addr;
    logic [7:0]                       s1_byte;
    logic                             v_store, v_sl, v_sm, v_fin, v_fail, v_newblk;
    lz4bd_pkg::t_err_code             v_code;
    logic [32:0]                      v_sum;
    logic [32:0]                      v_diff;
    logic [lz4bd_pkg::HIST_AW-1:0]    v_off;
    lz4bd_pkg::t_result               res_byte, res_end, push0;
    logic [1:0]                       npush;
    logic                             pop;

    assign acc     = i_in_valid && !o_in_stall;
    assign rd_addr = r_prod[lz4bd_pkg::HIST_AW-1:0] - r_off;
    assign s1_byte = r_s1.from_mem ? (r_fwd ? r_fwd_data : r_mem_q) : r_s1.lit_byte;

    always_comb begin
        n_phase   = r_phase;
        n_lit     = r_lit;
        n_nib     = r_nib;
        n_off     = r_off;
        n_rem     = r_rem;
        n_prod    = r_prod;
        n_ended   = r_ended;
        n_cap     = r_cap;
        n_room    = r_room;
        n_room_ok = r_room_ok;
        n_s1      = '0;
        n_s1.end_kind = lz4bd_pkg::OUT_BYTE;
        n_s1.end_code = lz4bd_pkg::ERR_NONE;
        v_store   = 1'b0;
        v_sl      = 1'b0;
        v_sm      = 1'b0;
        v_fin     = 1'b0;
        v_fail    = 1'b0;
        v_newblk  = 1'b0;
        v_code    = lz4bd_pkg::ERR_NONE;
        v_sum     = '0;
        v_diff    = '0;
        v_off     = r_off;

        if (acc && i_kind) begin
            if (r_phase == lz4bd_pkg::PH_MATCH && r_rem != 32'd0) begin
                v_store        = 1'b1;
                n_rem          = r_rem - 32'd1;
                n_s1.byte_v    = 1'b1;
                n_s1.from_mem  = 1'b1;
                n_s1.match_left = n_rem;
                if (n_rem == 32'd0) begin
                    if (r_ended) begin
                        v_fin = 1'b1;
                    end else begin
                        n_phase = lz4bd_pkg::PH_TOKEN;
                    end
                end
            end
        end else if (acc) begin
            case (r_phase)
                lz4bd_pkg::PH_DRAIN: begin
                    v_newblk = i_last_in;
                end
                lz4bd_pkg::PH_MATCH: begin
                    v_fail = 1'b1;
                    v_code = lz4bd_pkg::ERR_ORDER;
                end
                lz4bd_pkg::PH_TOKEN: begin
                    n_lit = {28'd0, i_in_byte[7:4]};
                    n_nib = i_in_byte[3:0];
                    if (i_in_byte[7:4] == lz4bd_pkg::NIBBLE_EXT && !i_last_in) begin
                        n_phase = lz4bd_pkg::PH_LITEXT;
                    end else begin
                        v_sl = 1'b1;
                    end
                end
                lz4bd_pkg::PH_LITEXT: begin
                    v_sum = {1'b0, r_lit} + {25'd0, i_in_byte};
                    n_lit = v_sum[32] ? '1 : v_sum[31:0];
                    v_sl  = (i_in_byte != lz4bd_pkg::EXT_MORE) || i_last_in;
                end
                lz4bd_pkg::PH_LITERALS: begin
                    v_store       = 1'b1;
                    n_lit         = r_lit - 32'd1;
                    n_s1.byte_v   = 1'b1;
                    n_s1.lit_byte = i_in_byte;
                    if (n_lit == 32'd0) begin
                        if (i_last_in) begin
                            v_fin = 1'b1;
                        end else begin
                            n_phase = lz4bd_pkg::PH_OFF_LO;
                        end
                    end else if (i_last_in) begin
                        v_fail = 1'b1;
                        v_code = lz4bd_pkg::ERR_TRUNCATED;
                    end
                end
                lz4bd_pkg::PH_OFF_LO: begin
                    if (i_last_in) begin
                        v_fail = 1'b1;
                        v_code = lz4bd_pkg::ERR_TRUNCATED;
                    end else begin
                        n_off   = {8'd0, i_in_byte};
                        n_phase = lz4bd_pkg::PH_OFF_HI;
                    end
                end
                lz4bd_pkg::PH_OFF_HI: begin
                    v_off = {i_in_byte, r_off[7:0]};
                    n_off = v_off;
                    if (v_off == '0) begin
                        v_fail = 1'b1;
                        v_code = lz4bd_pkg::ERR_ZERO_OFF;
                    end else begin
                        n_rem = {28'd0, r_nib} + lz4bd_pkg::MIN_MATCH;
                        if (r_nib == lz4bd_pkg::NIBBLE_EXT && !i_last_in) begin
                            n_phase = lz4bd_pkg::PH_MATEXT;
                        end else begin
                            v_sm = 1'b1;
                        end
                    end
                end
                lz4bd_pkg::PH_MATEXT: begin
                    v_sum = {1'b0, r_rem} + {25'd0, i_in_byte};
                    n_rem = v_sum[32] ? '1 : v_sum[31:0];
                    v_sm  = (i_in_byte != lz4bd_pkg::EXT_MORE) || i_last_in;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (v_sl) begin
            if (!(r_room_ok && n_lit <= r_room)) begin
                v_fail = 1'b1;
                v_code = lz4bd_pkg::ERR_CAPACITY;
            end else if (n_lit == 32'd0) begin
                if (i_last_in) begin
                    v_fin = 1'b1;
                end else begin
                    n_phase = lz4bd_pkg::PH_OFF_LO;
                end
            end else if (i_last_in) begin
                v_fail = 1'b1;
                v_code = lz4bd_pkg::ERR_TRUNCATED;
            end else begin
                n_phase = lz4bd_pkg::PH_LITERALS;
            end
        end

        if (v_sm) begin
            if ({16'd0, v_off} > r_prod) begin
                v_fail = 1'b1;
                v_code = lz4bd_pkg::ERR_FAR_OFF;
            end else if (!(r_room_ok && n_rem <= r_room)) begin
                v_fail = 1'b1;
                v_code = lz4bd_pkg::ERR_CAPACITY;
            end else begin
                n_phase = lz4bd_pkg::PH_MATCH;
                n_ended = i_last_in;
            end
        end

        if (v_store) begin
            n_prod     = r_prod + 32'd1;
            n_s1.wr    = 1'b1;
            n_s1.waddr = r_prod[lz4bd_pkg::HIST_AW-1:0];
            n_room     = r_room - 32'd1;
            if (r_room == 32'd0) begin
                n_room_ok = 1'b0;
            end
        end
        n_s1.produced = n_prod;

        if (v_fail) begin
            n_s1.end_v    = 1'b1;
            n_s1.end_kind = lz4bd_pkg::OUT_ERROR;
            n_s1.end_code = v_code;
            if (i_last_in || r_ended) begin
                v_newblk = 1'b1;
            end else begin
                n_phase = lz4bd_pkg::PH_DRAIN;
            end
        end
        if (v_fin) begin
            n_s1.end_v    = 1'b1;
            n_s1.end_kind = lz4bd_pkg::OUT_FINISH;
            v_newblk      = 1'b1;
        end

        if (v_newblk) begin
            n_phase   = lz4bd_pkg::PH_TOKEN;
            n_lit     = '0;
            n_nib     = '0;
            n_off     = '0;
            n_rem     = '0;
            n_prod    = '0;
            n_ended   = 1'b0;
            n_room    = r_cap;
            n_room_ok = 1'b1;
        end

        if (i_cfg_we) begin
            v_diff    = {1'b0, i_cfg_wdata} - {1'b0, n_prod};
            n_cap     = i_cfg_wdata;
            n_room    = v_diff[31:0];
            n_room_ok = !v_diff[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lz4bd_pkg::PH_TOKEN;
            r_lit      <= '0;
            r_nib      <= '0;
            r_off      <= '0;
            r_rem      <= '0;
            r_prod     <= '0;
            r_ended    <= 1'b0;
            r_cap      <= '1;
            r_room     <= '1;
            r_room_ok  <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_lit      <= n_lit;
            r_nib      <= n_nib;
            r_off      <= n_off;
            r_rem      <= n_rem;
            r_prod     <= n_prod;
            r_ended    <= n_ended;
            r_cap      <= n_cap;
            r_room     <= n_room;
            r_room_ok  <= n_room_ok;
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_fwd      <= r_s1_valid && r_s1.wr && (r_s1.waddr == rd_addr);
        r_fwd_data <= s1_byte;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1.wr) begin
            r_hist[r_s1.waddr] <= s1_byte;
        end
        r_mem_q <= r_hist[rd_addr];
    end

    always_comb begin
        res_byte.kind = lz4bd_pkg::OUT_BYTE;
        res_byte.data = s1_byte;
        res_byte.code = lz4bd_pkg::ERR_NONE;
        res_byte.left = r_s1.match_left;
        res_byte.prod = r_s1.produced;
        res_byte.fin  = 1'b0;
        res_end.kind  = r_s1.end_kind;
        res_end.data  = 8'd0;
        res_end.code  = r_s1.end_code;
        res_end.left  = 32'd0;
        res_end.prod  = r_s1.produced;
        res_end.fin   = 1'b1;
        push0 = r_s1.byte_v ? res_byte : res_end;
        npush = r_s1_valid ? ({1'b0, r_s1.byte_v} + {1'b0, r_s1.end_v}) : 2'd0;
    end

    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_in_stall  = (r_count > lz4bd_pkg::FIFO_CW'(lz4bd_pkg::STALL_LEVEL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + lz4bd_pkg::FIFO_AW'(npush);
            r_rp    <= r_rp + lz4bd_pkg::FIFO_AW'(pop);
            r_count <= r_count + lz4bd_pkg::FIFO_CW'(npush) - lz4bd_pkg::FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (npush != 2'd0) begin
            r_fifo[r_wp] <= push0;
        end
        if (npush == 2'd2) begin
            r_fifo[r_wp + lz4bd_pkg::FIFO_AW'(1)] <= res_end;
        end
    end

    assign o_out_kind   = r_fifo[r_rp].kind;
    assign o_out_byte   = r_fifo[r_rp].data;
    assign o_error_code = r_fifo[r_rp].code;
    assign o_match_left = r_fifo[r_rp].left;
    assign o_produced   = r_fifo[r_rp].prod;
    assign o_block_end  = r_fifo[r_rp].fin;

endmodule

`default_nettype wire

### hdl/lz4bd_checker.sv
// Port checker for the LZ4 block decoder, bound to the top level.
// Depends on lz4bd_pkg for the result and error codes.
`default_nettype none

module lz4bd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_out_kind,
    input wire logic [7:0]  o_out_byte,
    input wire logic [2:0]  o_error_code,
    input wire logic [31:0] o_match_left,
    input wire logic [31:0] o_produced,
    input wire logic        o_block_end
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while no result is queued");

    a_byte_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == lz4bd_pkg::OUT_BYTE)
            |-> (!o_block_end && o_error_code == lz4bd_pkg::ERR_NONE))
        else $error("decoded byte carries an end mark or an error code");

    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_kind == lz4bd_pkg::OUT_FINISH
                         || o_out_kind == lz4bd_pkg::OUT_ERROR))
            |-> (o_block_end && o_match_left == 32'd0 && o_out_byte == 8'd0
                 && ((o_out_kind == lz4bd_pkg::OUT_ERROR)
                     == (o_error_code != lz4bd_pkg::ERR_NONE))))
        else $error("finish or error item is malformed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_out_kind) && $stable(o_out_byte)
                 && $stable(o_produced)))
        else $error("stalled result item changed");

endmodule

bind lz4_block_decompressor lz4bd_checker u_lz4bd_checker (.*);

`default_nettype wire
